// ===== hdl/smsv_pkg.sv =====
// ----------------------------------------------------------------------------
// smsv_pkg
// Shared types and constants for the shader module stream validator.
// ----------------------------------------------------------------------------
package smsv_pkg;

  localparam int unsigned MAX_WORDS = 262144;
  localparam int unsigned POS_W     = 19;   // holds 0..MAX_WORDS
  localparam int unsigned SUM_W     = 20;   // start + 16-bit length
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned BOUND_W   = 22;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [WORD_W-1:0] MODULE_MAGIC = 32'h0723_0203;
  localparam logic [WORD_W-1:0] VERSION_MIN  = 32'h0001_0000;
  localparam logic [WORD_W-1:0] VERSION_MAX  = 32'h0001_0600;
  localparam logic [POS_W-1:0]  HEADER_WORDS = POS_W'(5);
  localparam logic [POS_W-1:0]  MAX_POS      = POS_W'(MAX_WORDS);

  localparam logic [WORD_W-1:0]  TARGET_VERSION_RST = 32'h0001_0000;
  localparam logic [BOUND_W-1:0] ID_BOUND_LIMIT_RST = 22'h3F_FFFF;

  typedef enum logic [IDX_W-1:0] {
    CFG_TARGET_VERSION = 2'd0,
    CFG_ID_BOUND_LIMIT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0]  target_version;
    logic [BOUND_W-1:0] id_bound_limit;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] module_word;
    logic              last_word;
    logic              partial_tail;
  } item_t;

  typedef struct packed {
    logic             module_ok;
    logic [POS_W-1:0] words_seen;
  } result_t;

endpackage

// ===== hdl/smsv_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// smsv_cfg_regs
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module smsv_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [smsv_pkg::IDX_W-1:0]     cfg_index,
  input  logic [smsv_pkg::WORD_W-1:0]    cfg_wdata,
  output smsv_pkg::cfg_t                 cfg
);

  smsv_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        smsv_pkg::CFG_TARGET_VERSION: cfg_nxt.target_version = cfg_wdata;
        smsv_pkg::CFG_ID_BOUND_LIMIT:
          cfg_nxt.id_bound_limit = cfg_wdata[smsv_pkg::BOUND_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_version <= smsv_pkg::TARGET_VERSION_RST;
      cfg_r.id_bound_limit <= smsv_pkg::ID_BOUND_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/smsv_in_stage.sv =====
// ----------------------------------------------------------------------------
// smsv_in_stage
// Input register: holds one request until the checker consumes it.
// ----------------------------------------------------------------------------
module smsv_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  smsv_pkg::item_t in_item,
  input  logic            consume,
  output logic            item_valid,
  output smsv_pkg::item_t item
);

  logic            valid_r, valid_nxt;
  smsv_pkg::item_t item_r, item_nxt;

  assign in_ready = !valid_r || consume;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      if (in_valid) item_nxt = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hdl/smsv_core.sv =====
// ----------------------------------------------------------------------------
// smsv_core
// Header and instruction length checks; per-module state and verdict.
// ----------------------------------------------------------------------------
module smsv_core (
  input  logic             clk,
  input  logic             rst_n,
  input  smsv_pkg::cfg_t   cfg,
  input  logic             item_valid,
  input  smsv_pkg::item_t  item,
  input  logic             out_free,
  output logic             consume,
  output logic             res_valid,
  output smsv_pkg::result_t res
);

  logic [smsv_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [smsv_pkg::POS_W-1:0] nis_r, nis_nxt;
  logic                       err_r, err_nxt;

  logic [smsv_pkg::WORD_W-1:0] w;
  logic [smsv_pkg::LEN_W-1:0]  len;
  logic [smsv_pkg::SUM_W-1:0]  nis_sum;
  logic                        hdr_bad;
  logic [smsv_pkg::POS_W-1:0]  upd_pos;
  logic [smsv_pkg::POS_W-1:0]  upd_nis;
  logic                        upd_err;

  assign consume   = item_valid && (!item.last_word || out_free);
  assign res_valid = consume && item.last_word;

  assign w       = item.module_word;
  assign len     = w[smsv_pkg::WORD_W-1:smsv_pkg::LEN_W];
  assign nis_sum = smsv_pkg::SUM_W'(nis_r) + smsv_pkg::SUM_W'(len);

  always_comb begin
    hdr_bad = 1'b0;
    unique case (pos_r)
      smsv_pkg::POS_W'(0): hdr_bad = (w != smsv_pkg::MODULE_MAGIC);
      smsv_pkg::POS_W'(1): hdr_bad = (w < smsv_pkg::VERSION_MIN) ||
                                     (w > smsv_pkg::VERSION_MAX) ||
                                     (w != cfg.target_version);
      smsv_pkg::POS_W'(3): hdr_bad = (w == '0) ||
                                     (w[smsv_pkg::WORD_W-1:smsv_pkg::BOUND_W] != '0) ||
                                     (w[smsv_pkg::BOUND_W-1:0] > cfg.id_bound_limit);
      smsv_pkg::POS_W'(4): hdr_bad = (w != '0);
      default:             hdr_bad = 1'b0;
    endcase
  end

  always_comb begin
    upd_pos = pos_r;
    upd_nis = nis_r;
    upd_err = err_r;
    if (pos_r >= smsv_pkg::MAX_POS) begin
      upd_err = 1'b1;
    end else begin
      upd_pos = pos_r + smsv_pkg::POS_W'(1);
      if (pos_r < smsv_pkg::HEADER_WORDS) begin
        if (hdr_bad) upd_err = 1'b1;
      end else if (pos_r == nis_r) begin
        if (len == '0 || nis_sum > smsv_pkg::SUM_W'(smsv_pkg::MAX_WORDS)) begin
          upd_err = 1'b1;
        end else begin
          upd_nis = nis_sum[smsv_pkg::POS_W-1:0];
        end
      end
    end
  end

  always_comb begin
    res.words_seen = upd_pos;
    res.module_ok  = !upd_err && !item.partial_tail &&
                     (upd_pos >= smsv_pkg::HEADER_WORDS) && (upd_nis == upd_pos);
  end

  always_comb begin
    pos_nxt = pos_r;
    nis_nxt = nis_r;
    err_nxt = err_r;
    if (consume) begin
      if (item.last_word) begin
        pos_nxt = '0;
        nis_nxt = smsv_pkg::HEADER_WORDS;
        err_nxt = 1'b0;
      end else begin
        pos_nxt = upd_pos;
        nis_nxt = upd_nis;
        err_nxt = upd_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      nis_r <= smsv_pkg::HEADER_WORDS;
      err_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      nis_r <= nis_nxt;
      err_r <= err_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= smsv_pkg::MAX_POS)
    else $error("word position beyond limit");

  a_nis_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nis_r >= smsv_pkg::HEADER_WORDS) && (nis_r <= smsv_pkg::MAX_POS))
    else $error("instruction start out of range");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (pos_r == '0) && !err_r && (nis_r == smsv_pkg::HEADER_WORDS))
    else $error("state not restarted after verdict");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && !(consume && item.last_word)) |=> err_r)
    else $error("error flag dropped inside a module");

endmodule

// ===== hdl/smsv_out_stage.sv =====
// ----------------------------------------------------------------------------
// smsv_out_stage
// Result register toward the output stream.
// ----------------------------------------------------------------------------
module smsv_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  smsv_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output smsv_pkg::result_t out_res
);

  logic              valid_r, valid_nxt;
  smsv_pkg::result_t res_r, res_nxt;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/spirv_module_stream_validator.sv =====
// ----------------------------------------------------------------------------
// spirv_module_stream_validator
// Checks a shader module word stream: header fields and instruction lengths.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake          | Contents
// in_     | in  | in_tvalid/tready   | module word, last mark, partial tail
// out_    | out | out_tvalid/tready  | one verdict per module
// cfg_    | in  | cfg_we             | target version, id bound limit
//
// One word per cycle unless a last word waits on a busy output stage; a word is registered
// in the input stage and its verdict in the output stage. The rate is set by the combinational
// length add and compare on the word. Reset clears all module state; config returns to its
// reset values. A stalled verdict holds only last words; other words keep flowing.
// ----------------------------------------------------------------------------
module spirv_module_stream_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] module_word
  input  logic        in_tlast,
  input  logic        in_tuser,   // [0] partial_tail
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [18:0] words_seen, rest zero
  output logic        out_tuser,  // [0] module_ok
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  smsv_pkg::cfg_t    cfg;
  smsv_pkg::item_t   in_item;
  smsv_pkg::item_t   item;
  smsv_pkg::result_t res;
  smsv_pkg::result_t out_res;
  logic              item_valid;
  logic              consume;
  logic              res_valid;
  logic              out_free;

  assign in_item.module_word  = in_tdata;
  assign in_item.last_word    = in_tlast;
  assign in_item.partial_tail = in_tuser;

  smsv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  smsv_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  smsv_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .consume    (consume),
    .res_valid  (res_valid),
    .res        (res)
  );

  smsv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{(smsv_pkg::OUT_TDATA_W - smsv_pkg::POS_W){1'b0}}, out_res.words_seen};
  assign out_tuser = out_res.module_ok;

endmodule
